@@ hw/rtl/plist_pkg.sv @@
// Shared types and codes for the positional list engine.
package plist_pkg;

  localparam int POS_W = 8;
  localparam int VAL_W = 32;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_GET    = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic signed [VAL_W-1:0] TOP_VALUE = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] NO_POS    = -8'sd1;

  typedef struct packed {
    logic [1:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } plist_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic signed [POS_W-1:0] found_position;
  } plist_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic rd;    // issue a store read
    logic use_d; // act on read data
    logic put;   // write the inserted value
    logic fin;   // load the result register
  } plist_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] act;
    logic       ok;
    logic       more;
    logic       out_busy;
  } plist_sts_t;

endpackage

@@ hw/rtl/plist_ctrl.sv @@
// Sequencer for the positional list engine.
module plist_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  plist_pkg::plist_sts_t sts,
  output plist_pkg::plist_cmd_t cmd
);
  import plist_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_USE  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // sequence one word at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (!sts.ok) begin
          state_nxt = S_FIN;
        end else if (sts.more) begin
          state_nxt = S_READ;
        end else if (sts.act == ACT_INSERT) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_USE;
      end
      S_USE: begin
        cmd.use_d = 1'b1;
        state_nxt = S_STEP;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ hw/rtl/plist_dp.sv @@
// Datapath of the positional list engine: entry store, count, index and result.
module plist_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  plist_pkg::plist_in_t   in_data,
  input  plist_pkg::plist_cmd_t  cmd,
  output plist_pkg::plist_sts_t  sts,
  output logic                   out_valid,
  input  logic                   out_stall,
  output plist_pkg::plist_out_t  out_data
);
  import plist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;

  logic [CW-1:0]           count_r;
  logic [CW-1:0]           idx_r;
  logic [CW-1:0]           slot_r;
  logic [1:0]              act_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    ok_r;
  logic                    hit_r;
  logic                    out_valid_r;
  plist_out_t              out_r;

  logic [POS_W-1:0] cnt8;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W-1:0] ins_slot;
  logic [CW-1:0]    rd_addr_w;
  logic [CW:0]      idx_inc;
  logic             more;

  assign cnt8     = {{(POS_W-CW){1'b0}}, count_r};
  assign pos_m1   = (in_data.position <= 8'd1) ? '0 : in_data.position - 8'd1;
  assign ins_slot = (pos_m1 > cnt8) ? cnt8 : pos_m1;
  assign idx_inc  = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};

  // work left for the current word
  always_comb begin
    case (act_r)
      ACT_INSERT: more = (idx_r > slot_r);
      ACT_DELETE: more = (idx_inc < {1'b0, count_r});
      ACT_GET:    more = !hit_r;
      default:    more = !hit_r && (idx_r < count_r);
    endcase
  end

  // read address: insert pulls from below, delete from above
  always_comb begin
    case (act_r)
      ACT_INSERT: rd_addr_w = idx_r - CW'(1);
      ACT_DELETE: rd_addr_w = idx_inc[CW-1:0];
      default:    rd_addr_w = idx_r;
    endcase
  end

  // capture the word and set up the walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_data.action;
      value_r <= in_data.value;
      hit_r   <= 1'b0;
      case (in_data.action)
        ACT_INSERT: begin
          ok_r   <= (count_r < CAP_C);
          idx_r  <= count_r;
          slot_r <= ins_slot[CW-1:0];
        end
        ACT_DELETE: begin
          ok_r   <= (in_data.position >= 8'd1) && (in_data.position <= cnt8);
          idx_r  <= pos_m1[CW-1:0];
          slot_r <= '0;
        end
        ACT_GET: begin
          ok_r   <= (pos_m1 < cnt8);
          idx_r  <= pos_m1[CW-1:0];
          slot_r <= '0;
        end
        default: begin
          ok_r   <= 1'b1;
          idx_r  <= '0;
          slot_r <= '0;
        end
      endcase
    end else if (cmd.use_d) begin
      case (act_r)
        ACT_INSERT: idx_r <= idx_r - CW'(1);
        ACT_DELETE: idx_r <= idx_inc[CW-1:0];
        ACT_GET:    hit_r <= 1'b1;
        default: begin
          if (rd_data_r == value_r) begin
            hit_r <= 1'b1;
          end else begin
            idx_r <= idx_inc[CW-1:0];
          end
        end
      endcase
    end
  end

  // entry store: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr_w[AW-1:0]];
    end
    if (cmd.use_d && (act_r == ACT_INSERT || act_r == ACT_DELETE)) begin
      mem[idx_r[AW-1:0]] <= rd_data_r;
    end else if (cmd.put) begin
      mem[slot_r[AW-1:0]] <= value_r;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.put) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.fin && act_r == ACT_DELETE && ok_r) begin
      count_r <= count_r - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      case (act_r)
        ACT_INSERT: begin
          out_r.status         <= ok_r ? ST_DONE : ST_FULL;
          out_r.read_value     <= '0;
          out_r.found_position <= '0;
        end
        ACT_DELETE: begin
          out_r.status         <= ok_r ? ST_DONE : ST_MISS;
          out_r.read_value     <= '0;
          out_r.found_position <= '0;
        end
        ACT_GET: begin
          out_r.status         <= ok_r ? ST_DONE : ST_MISS;
          out_r.read_value     <= ok_r ? rd_data_r : TOP_VALUE;
          out_r.found_position <= '0;
        end
        default: begin
          out_r.status         <= hit_r ? ST_DONE : ST_MISS;
          out_r.read_value     <= '0;
          out_r.found_position <= hit_r ? ({{(POS_W-CW){1'b0}}, idx_r} + 8'd1) : NO_POS;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.act      = act_r;
  assign sts.ok       = ok_r;
  assign sts.more     = more;
  assign sts.out_busy = out_valid_r && out_stall;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !(out_valid_r && out_stall))
    else $error("result loaded over a waiting word");

  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.put && !cmd.fin |=> $stable(count_r))
    else $error("entry count moved outside insert or delete");

  a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> (count_r < CAP_C) && (slot_r <= count_r))
    else $error("insert write without room");
`endif

endmodule

@@ hw/rtl/positional_list_engine_core.sv @@
// Top level of the positional list engine: controller plus datapath.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_stall   | action, position, value
//  out_    | output    | out_valid / out_stall | status, read_value, found_position
//
// One word is worked at a time; the walk over the entry store sets the pace.
// Each entry moved or compared takes a store read step and a use step; insert
// then writes the new value, get reads one entry, a refused word goes to the result.
// The next word can be taken in the cycle after its result is loaded.
// Reset clears the entry count and the result valid; the store is left as is.
// A new word is taken while an earlier result still waits on out_stall.
module positional_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  plist_pkg::plist_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output plist_pkg::plist_out_t  out_data
);
  import plist_pkg::*;

  plist_cmd_t cmd;
  plist_sts_t sts;

  plist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  plist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
